### rtl/bal_pkg.sv
`timescale 1ns / 1ps

package bal_pkg;

  // List geometry
  localparam int CAPACITY = 8;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = 4;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int FIDX_W   = 5;
  localparam int ST_W     = 3;
  localparam int FN_W     = 3;
  localparam int STEP_W   = 4;

  // Operation codes
  localparam logic [FN_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FN_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FN_W-1:0] FN_INS_AT    = 3'd2;
  localparam logic [FN_W-1:0] FN_REM_FRONT = 3'd3;
  localparam logic [FN_W-1:0] FN_REM_BACK  = 3'd4;
  localparam logic [FN_W-1:0] FN_REM_AT    = 3'd5;
  localparam logic [FN_W-1:0] FN_REM_VAL   = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_INS_TEST = 4'd1;
  localparam logic [STEP_W-1:0] S_INS_MOVE = 4'd2;
  localparam logic [STEP_W-1:0] S_INS_PUT  = 4'd3;
  localparam logic [STEP_W-1:0] S_REM_RD   = 4'd4;
  localparam logic [STEP_W-1:0] S_REM_CAP  = 4'd5;
  localparam logic [STEP_W-1:0] S_REM_TEST = 4'd6;
  localparam logic [STEP_W-1:0] S_REM_MOVE = 4'd7;
  localparam logic [STEP_W-1:0] S_REM_DONE = 4'd8;
  localparam logic [STEP_W-1:0] S_SRCH_RD  = 4'd9;
  localparam logic [STEP_W-1:0] S_SRCH_CMP = 4'd10;
  localparam logic [STEP_W-1:0] S_SRCH_END = 4'd11;
  localparam logic [STEP_W-1:0] S_NOTFOUND = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd13;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_PTR_EQ_TGT,
    C_PTR_EQ_CNT,
    C_LAST,
    C_HIT,
    C_OUT_FREE,
    C_ACCEPT
  } cond_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_e;

  typedef enum logic {
    WR_VAL,
    WR_RDATA
  } wr_sel_e;

  typedef enum logic [1:0] {
    P_HOLD,
    P_DEC,
    P_INC,
    P_LOAD_AT
  } ptr_op_e;

  typedef enum logic [2:0] {
    M_NONE,
    M_CAP_DATA,
    M_CMP,
    M_CNT_INC,
    M_CNT_DEC,
    M_NOTFOUND,
    M_EMIT
  } misc_e;

  typedef struct packed {
    cond_e               cond;
    logic                stall;
    logic [STEP_W-1:0]   target;
    rd_sel_e             rd_sel;
    logic                wr_en;
    wr_sel_e             wr_sel;
    ptr_op_e             ptr_op;
    misc_e               misc;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic ptr_eq_tgt;
    logic ptr_eq_cnt;
    logic last;
    logic hit;
    logic out_free;
  } flags_t;

  // Control store: one word per step.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{cond: C_NEXT, stall: 1'b0, target: S_IDLE, rd_sel: RD_PTR, wr_en: 1'b0,
          wr_sel: WR_VAL, ptr_op: P_HOLD, misc: M_NONE};
    case (step)
      S_IDLE: begin
        w.cond  = C_ACCEPT;
        w.stall = 1'b1;
      end
      S_INS_TEST: begin
        w.rd_sel = RD_PTR_M1;
        w.cond   = C_PTR_EQ_TGT;
        w.target = S_INS_PUT;
      end
      S_INS_MOVE: begin
        w.wr_en  = 1'b1;
        w.wr_sel = WR_RDATA;
        w.ptr_op = P_DEC;
        w.cond   = C_ALWAYS;
        w.target = S_INS_TEST;
      end
      S_INS_PUT: begin
        w.wr_en  = 1'b1;
        w.wr_sel = WR_VAL;
        w.misc   = M_CNT_INC;
        w.cond   = C_ALWAYS;
        w.target = S_EMIT;
      end
      S_REM_RD: begin
        w.rd_sel = RD_PTR;
      end
      S_REM_CAP: begin
        w.misc = M_CAP_DATA;
      end
      S_REM_TEST: begin
        w.rd_sel = RD_PTR_P1;
        w.cond   = C_LAST;
        w.target = S_REM_DONE;
      end
      S_REM_MOVE: begin
        w.wr_en  = 1'b1;
        w.wr_sel = WR_RDATA;
        w.ptr_op = P_INC;
        w.cond   = C_ALWAYS;
        w.target = S_REM_TEST;
      end
      S_REM_DONE: begin
        w.misc   = M_CNT_DEC;
        w.cond   = C_ALWAYS;
        w.target = S_EMIT;
      end
      S_SRCH_RD: begin
        w.rd_sel = RD_PTR;
        w.cond   = C_PTR_EQ_CNT;
        w.target = S_SRCH_END;
      end
      S_SRCH_CMP: begin
        w.misc   = M_CMP;
        w.ptr_op = P_INC;
        w.cond   = C_ALWAYS;
        w.target = S_SRCH_RD;
      end
      S_SRCH_END: begin
        w.ptr_op = P_LOAD_AT;
        w.cond   = C_HIT;
        w.target = S_REM_RD;
      end
      S_NOTFOUND: begin
        w.misc   = M_NOTFOUND;
        w.cond   = C_ALWAYS;
        w.target = S_EMIT;
      end
      S_EMIT: begin
        w.misc   = M_EMIT;
        w.cond   = C_OUT_FREE;
        w.stall  = 1'b1;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/bal_ram.sv
`timescale 1ns / 1ps

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bal_seq.sv
`timescale 1ns / 1ps

module bal_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bal_pkg::flags_t        flags_i,
  input  logic [bal_pkg::STEP_W-1:0] disp_step_i,
  output bal_pkg::ctrl_t         ctrl_o
);
  import bal_pkg::*;

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             ctrl;
  logic              taken;

  assign ctrl = rom_word(pc_q);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:       taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_PTR_EQ_TGT: taken = flags_i.ptr_eq_tgt;
      C_PTR_EQ_CNT: taken = flags_i.ptr_eq_cnt;
      C_LAST:       taken = flags_i.last;
      C_HIT:        taken = flags_i.hit;
      C_OUT_FREE:   taken = flags_i.out_free;
      C_ACCEPT:     taken = flags_i.accept;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = (ctrl.cond == C_ACCEPT) ? disp_step_i : ctrl.target;
    end else if (ctrl.stall) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

### rtl/bounded_array_list_core.sv
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values, up to eight entries.
// Input channel (s_axis_*): one transaction is one operation; tuser carries the
// operation code, tdata the value and the position. Output channel (m_axis_*):
// exactly one result transaction per operation, in order, carrying the removed
// value, the found index, count and empty/full flags in tdata, status in tuser.
// Operations run one at a time under a microprogram that steps through the entry
// memory: a single-port-write, registered-read RAM moves each entry with a read
// step and then a write step. Insert shifts the entries at and above the position
// up by one, remove shifts the entries above the position down by one, remove by
// value searches the whole list and then removes the last match, and a rejected
// operation goes straight to the result step. The result sits in an output
// register, so a new operation is taken while the previous result still waits;
// only the final step of the next operation holds until the receiver takes the
// result. Reset empties the list (count to zero) and drops any pending result;
// entry storage is not cleared, only entries below the count are ever used.
module bounded_array_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input: tdata, low to high = value[31:0], position[35:32], pad[39:36]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Input: tuser, low to high = func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Output: tdata, low to high = data[31:0], found_index[36:32], count[40:37],
  //         is_empty[41], is_full[42], pad[47:43]
  output logic [47:0] m_axis_tdata,
  // Output: tuser, low to high = status[2:0]
  output logic [2:0]  m_axis_tuser
);
  import bal_pkg::*;

  ctrl_t             ctrl;
  flags_t            flags;
  logic [STEP_W-1:0] disp_step;

  logic              accept;
  logic [FN_W-1:0]   in_func;
  logic [VAL_W-1:0]  in_value;
  logic [POS_W-1:0]  in_pos;

  // Datapath registers
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [ST_W-1:0]   st_q, st_d;
  logic              hit_q, hit_d;
  logic [AW-1:0]     at_q, at_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  data_q, data_d;

  // Dispatch values
  logic [CNT_W-1:0]  ptr_init, tgt_init;
  logic [ST_W-1:0]   st_init;
  logic              full, empty;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [47:0]       out_tdata_q;
  logic [2:0]        out_tuser_q;
  logic              out_free, out_load;

  // RAM ports
  logic [AW-1:0]     raddr;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  wdata;
  logic [CNT_W-1:0]  ptr_m1, ptr_p1;
  logic [CNT_W:0]    ptr_p1_wide;
  logic [FIDX_W-1:0] fidx;

  assign in_func  = s_axis_tuser;
  assign in_value = s_axis_tdata[VAL_W-1:0];
  assign in_pos   = s_axis_tdata[VAL_W+POS_W-1:VAL_W];

  // Ready only while the sequencer waits in its idle step.
  assign s_axis_tready = (ctrl.cond == C_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (cnt_q >= CNT_W'(CAPACITY));
  assign empty = (cnt_q == '0);

  // Decode the operation: pick the entry step, starting pointer and target,
  // and route rejected operations straight to the result step.
  always_comb begin
    disp_step = S_EMIT;
    ptr_init  = '0;
    tgt_init  = '0;
    st_init   = ST_OK;
    case (in_func)
      FN_INS_FRONT: begin
        if (full) begin
          st_init = ST_FULL;
        end else begin
          disp_step = S_INS_TEST;
          ptr_init  = cnt_q;
        end
      end
      FN_INS_BACK: begin
        if (full) begin
          st_init = ST_FULL;
        end else begin
          disp_step = S_INS_TEST;
          ptr_init  = cnt_q;
          tgt_init  = cnt_q;
        end
      end
      FN_INS_AT: begin
        if (full) begin
          st_init = ST_FULL;
        end else if (in_pos > cnt_q) begin
          st_init = ST_BADPOS;
        end else begin
          disp_step = S_INS_TEST;
          ptr_init  = cnt_q;
          tgt_init  = in_pos;
        end
      end
      FN_REM_FRONT: begin
        if (empty) begin
          st_init = ST_EMPTY;
        end else begin
          disp_step = S_REM_RD;
        end
      end
      FN_REM_BACK: begin
        if (empty) begin
          st_init = ST_EMPTY;
        end else begin
          disp_step = S_REM_RD;
          ptr_init  = cnt_q - CNT_W'(1);
        end
      end
      FN_REM_AT: begin
        if (empty) begin
          st_init = ST_EMPTY;
        end else if (in_pos >= cnt_q) begin
          st_init = ST_BADPOS;
        end else begin
          disp_step = S_REM_RD;
          ptr_init  = in_pos;
        end
      end
      FN_REM_VAL: begin
        if (empty) begin
          st_init = ST_EMPTY;
        end else begin
          disp_step = S_SRCH_RD;
        end
      end
      default: begin
        st_init = ST_OK;
      end
    endcase
  end

  // Pointer neighbors for the shift loops
  assign ptr_m1      = ptr_q - CNT_W'(1);
  assign ptr_p1_wide = {1'b0, ptr_q} + (CNT_W+1)'(1);
  assign ptr_p1      = ptr_p1_wide[CNT_W-1:0];

  assign out_free = !out_valid_q || m_axis_tready;

  assign flags = '{accept:     accept,
                   ptr_eq_tgt: (ptr_q == tgt_q),
                   ptr_eq_cnt: (ptr_q == cnt_q),
                   last:       (ptr_p1_wide >= {1'b0, cnt_q}),
                   hit:        hit_q,
                   out_free:   out_free};

  bal_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flags_i     (flags),
    .disp_step_i (disp_step),
    .ctrl_o      (ctrl)
  );

  always_comb begin
    case (ctrl.rd_sel)
      RD_PTR:    raddr = ptr_q[AW-1:0];
      RD_PTR_M1: raddr = ptr_m1[AW-1:0];
      RD_PTR_P1: raddr = ptr_p1[AW-1:0];
      default:   raddr = ptr_q[AW-1:0];
    endcase
  end

  assign wdata = (ctrl.wr_sel == WR_RDATA) ? rdata : val_q;

  bal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ctrl.wr_en),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Datapath next-state: execute the current control word.
  always_comb begin
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    tgt_d  = tgt_q;
    st_d   = st_q;
    hit_d  = hit_q;
    at_d   = at_q;
    val_d  = val_q;
    data_d = data_q;

    if (accept) begin
      ptr_d  = ptr_init;
      tgt_d  = tgt_init;
      st_d   = st_init;
      hit_d  = 1'b0;
      val_d  = in_value;
      data_d = '0;
    end else begin
      case (ctrl.ptr_op)
        P_HOLD:    ptr_d = ptr_q;
        P_DEC:     ptr_d = ptr_m1;
        P_INC:     ptr_d = ptr_p1;
        P_LOAD_AT: ptr_d = CNT_W'(at_q);
        default:   ptr_d = ptr_q;
      endcase
      case (ctrl.misc)
        M_CAP_DATA: data_d = rdata;
        M_CMP: begin
          // Keep the last match: later hits overwrite earlier ones.
          if (rdata == val_q) begin
            hit_d = 1'b1;
            at_d  = ptr_q[AW-1:0];
          end
        end
        M_CNT_INC:  cnt_d = cnt_q + CNT_W'(1);
        M_CNT_DEC:  cnt_d = cnt_q - CNT_W'(1);
        M_NOTFOUND: st_d  = ST_NOTFOUND;
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  // Load the result only when the output register is free.
  assign out_load    = (ctrl.misc == M_EMIT) && out_free;
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign fidx        = hit_q ? FIDX_W'(at_q) : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    tgt_q  <= tgt_d;
    st_q   <= st_d;
    at_q   <= at_d;
    val_q  <= val_d;
    data_q <= data_d;
    if (out_load) begin
      out_tdata_q <= {5'd0, full, empty, cnt_q, fidx, data_q};
      out_tuser_q <= st_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

  // Count never passes capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A successful insert only runs on a list that has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.misc == M_CNT_INC) |-> !full)
    else $error("insert committed on a full list");

  // A removal only commits on a list that holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.misc == M_CNT_DEC) |-> !empty)
    else $error("removal committed on an empty list");

  // Every accepted operation leaves the idle step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("sequencer stayed idle after accepting an operation");

endmodule
